// ===== hw/rtl/u2dec_pkg.sv =====
// Shared types and constants for the unsigned binary to decimal ASCII converter.
// No dependencies; imported by the controller, the datapath and the top level.

package u2dec_pkg;

  localparam int unsigned BIN_W     = 64;              // binary input width
  localparam int unsigned CAP_W     = 5;               // buffer_size width
  localparam int unsigned DIG_N     = 20;              // decimal digits of 2^64-1
  localparam int unsigned BCD_W     = 4 * DIG_N;       // packed BCD width
  localparam int unsigned MAX_CAP   = DIG_N + 1;       // digits plus terminator
  localparam int unsigned BIT_CNT_W = $clog2(BIN_W + 1);
  localparam int unsigned DIG_CNT_W = $clog2(DIG_N + 1);
  localparam int unsigned CHAR_W    = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NUL  = 8'h00;

  // Controller to datapath commands, at most one set per cycle.
  typedef struct packed {
    logic load;      // capture input, clear BCD, clamp capacity
    logic conv;      // one shift-add-3 step
    logic skip;      // drop one leading zero digit
    logic set_keep;  // keep = min(digit count, capacity - 1)
    logic emit;      // load the output register with a digit or the terminator
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic bits_done;  // all binary bits shifted in
    logic skip_more;  // top digit is a leading zero that can go
    logic keep_zero;  // no digits left to emit, terminator next
  } sts_t;

endpackage

// ===== hw/rtl/u2dec_in_if.sv =====
// Input channel: value and buffer size with a valid/ready handshake.
// Depends on u2dec_pkg for field widths.

interface u2dec_in_if;
  import u2dec_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [BIN_W-1:0]         value;
  logic [CAP_W-1:0]         buffer_size;

  modport source (output valid, output value, output buffer_size, input ready);
  modport sink   (input valid, input value, input buffer_size, output ready);
endinterface

// ===== hw/rtl/u2dec_out_if.sv =====
// Output channel: one ASCII byte per transfer, last on the terminator.
// Depends on u2dec_pkg for field widths.

interface u2dec_out_if;
  import u2dec_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== hw/rtl/unsigned_to_decimal_ascii.sv =====
// Top level of the unsigned 64-bit binary to decimal ASCII converter.
// Instantiates u2dec_ctrl and u2dec_dp; uses u2dec_pkg, u2dec_in_if, u2dec_out_if.
//
// Each accepted value comes out as its decimal digits in ASCII, most
// significant first with no leading zeros (zero gives "0"), cut to
// buffer_size-1 digits (0 acts as 1, above 21 as 21), then a NUL byte with
// last set. One item is worked at a time: the next item is accepted only
// after the terminator has been loaded into the output register. The
// bit-serial shift-add-3 converter takes one binary bit per cycle; then
// leading zeros are stripped one at a time and the bytes are emitted, with
// emission held while the output is stalled. The last byte sits in the
// output register while the next item is accepted.

module unsigned_to_decimal_ascii import u2dec_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  u2dec_in_if.sink     in_i,
  u2dec_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;

  u2dec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  u2dec_dp u_dp (
    .clk_i         (clk_i),
    .value_i       (in_i.value),
    .buffer_size_i (in_i.buffer_size),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .char_code_o   (out_o.char_code),
    .last_o        (out_o.last)
  );

endmodule

// ===== hw/rtl/u2dec_dp.sv =====
// Datapath: bit-serial shift-add-3 converter, leading zero strip, digit
// emission and the output byte register. Driven by u2dec_ctrl; uses u2dec_pkg.

module u2dec_dp import u2dec_pkg::*; (
  input  logic              clk_i,
  input  logic [BIN_W-1:0]  value_i,
  input  logic [CAP_W-1:0]  buffer_size_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [CHAR_W-1:0] char_code_o,
  output logic              last_o
);

  logic [BIN_W-1:0]     bin_q, bin_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0] ndig_q, ndig_d;
  logic [DIG_CNT_W-1:0] cap1_q, cap1_d;
  logic [DIG_CNT_W-1:0] keep_q, keep_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic                 last_q, last_d;
  logic [BCD_W-1:0]     bcd_adj;
  logic [3:0]           top_dig;

  // Add 3 to every digit of 5 or more; the digits are independent.
  function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int k = 0; k < DIG_N; k++) begin
      if (b[4*k +: 4] >= 4'd5) r[4*k +: 4] = b[4*k +: 4] + 4'd3;
    end
    return r;
  endfunction

  assign bcd_adj = add3(bcd_q);
  assign top_dig = bcd_q[BCD_W-1 -: 4];

  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    ndig_d    = ndig_q;
    cap1_d    = cap1_q;
    keep_d    = keep_q;
    char_d    = char_q;
    last_d    = last_q;
    if (cmd_i.load) begin
      bin_d     = value_i;
      bcd_d     = '0;
      bit_cnt_d = BIT_CNT_W'(BIN_W);
      ndig_d    = DIG_CNT_W'(DIG_N);
      if (buffer_size_i == '0)                        cap1_d = '0;
      else if (buffer_size_i > CAP_W'(MAX_CAP))       cap1_d = DIG_CNT_W'(DIG_N);
      else                                            cap1_d = buffer_size_i - 1'b1;
    end else if (cmd_i.conv) begin
      bcd_d     = {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
      bin_d     = {bin_q[BIN_W-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q - 1'b1;
    end else if (cmd_i.skip) begin
      bcd_d  = {bcd_q[BCD_W-5:0], 4'h0};
      ndig_d = ndig_q - 1'b1;
    end else if (cmd_i.set_keep) begin
      keep_d = (ndig_q < cap1_q) ? ndig_q : cap1_q;
    end else if (cmd_i.emit) begin
      if (keep_q != '0) begin
        char_d = ASCII_ZERO + {4'h0, top_dig};
        last_d = 1'b0;
        bcd_d  = {bcd_q[BCD_W-5:0], 4'h0};
        keep_d = keep_q - 1'b1;
      end else begin
        char_d = ASCII_NUL;
        last_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    ndig_q    <= ndig_d;
    cap1_q    <= cap1_d;
    keep_q    <= keep_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

  assign sts_o.bits_done = (bit_cnt_q == '0);
  assign sts_o.skip_more = (top_dig == 4'h0) && (ndig_q != DIG_CNT_W'(1));
  assign sts_o.keep_zero = (keep_q == '0);
  assign char_code_o     = char_q;
  assign last_o          = last_q;

endmodule

// ===== hw/rtl/u2dec_ctrl.sv =====
// Controller: sequences load, conversion, zero strip and emission, and owns
// the output valid flag. Talks to u2dec_dp through cmd_t/sts_t from u2dec_pkg.

module u2dec_ctrl import u2dec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       out_free;

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts_i.bits_done) state_d = ST_SKIP;
        else                 cmd_o.conv = 1'b1;
      end
      ST_SKIP: begin
        if (sts_i.skip_more) begin
          cmd_o.skip = 1'b1;
        end else begin
          cmd_o.set_keep = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          ovalid_d   = 1'b1;
          if (sts_i.keep_zero) state_d = ST_IDLE;  // terminator loaded
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;

`ifndef NO_ASSERTIONS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.conv, cmd_o.skip, cmd_o.set_keep, cmd_o.emit}))
    else $error("more than one datapath command");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!ovalid_q || out_ready_i))
    else $error("output byte overwritten before transfer");

  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CONV))
    else $error("accepted item did not start conversion");

  a_term_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && sts_i.keep_zero) |=> (state_q == ST_IDLE && ovalid_q))
    else $error("terminator not presented");

  a_no_out_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !cmd_o.emit)
    else $error("emission during conversion");
`endif

endmodule
